[rtl/ogdc_pkg.sv]
// Shared types, codes and helper functions for the obstacle-guarded drive controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ogdc_pkg;

  localparam int unsigned DUTY_MAX   = 8191;
  localparam int unsigned DUTY_W     = 13;
  localparam int unsigned ECHO_W     = 16;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    FUNC_MEASURE = 3'd0,
    FUNC_DRIVE   = 3'd1,
    FUNC_AUTO    = 3'd2,
    FUNC_MANUAL  = 3'd3,
    FUNC_PAUSE   = 3'd4,
    FUNC_RESUME  = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    CMD_FORWARD  = 3'd0,
    CMD_BACKWARD = 3'd1,
    CMD_LEFT     = 3'd2,
    CMD_RIGHT    = 3'd3,
    CMD_STOP     = 3'd4
  } drive_cmd_t;

  typedef enum logic [2:0] {
    MOTOR_STOP     = 3'd0,
    MOTOR_FORWARD  = 3'd1,
    MOTOR_BACKWARD = 3'd2,
    MOTOR_LEFT     = 3'd3,
    MOTOR_RIGHT    = 3'd4
  } motor_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_TURN_ECHO   = 3'd0,
    CFG_MANUAL_STOP_ECHO = 3'd1,
    CFG_AUTO_SPEED       = 3'd2,
    CFG_FORWARD_SPEED    = 3'd3,
    CFG_REVERSE_SPEED    = 3'd4,
    CFG_SPIN_SPEED       = 3'd5
  } cfg_idx_t;

  localparam logic [3:0] PINS_STOP     = 4'h0;
  localparam logic [3:0] PINS_FORWARD  = 4'h5;
  localparam logic [3:0] PINS_BACKWARD = 4'hA;
  localparam logic [3:0] PINS_LEFT     = 4'h6;
  localparam logic [3:0] PINS_RIGHT    = 4'h9;

  // Controller state carried from one request to the next.
  typedef struct packed {
    logic              mode_auto;
    logic              run_enabled;
    motor_t            drive_state;
    logic [DUTY_W-1:0] duty_now;
  } state_t;

  // Register file contents; speeds are held already converted to duty.
  typedef struct packed {
    logic [ECHO_W-1:0] auto_turn_echo;
    logic [ECHO_W-1:0] manual_stop_echo;
    logic [DUTY_W-1:0] auto_duty;
    logic [DUTY_W-1:0] forward_duty;
    logic [DUTY_W-1:0] reverse_duty;
    logic [DUTY_W-1:0] spin_duty;
  } cfg_t;

  // Percent to duty, pct * 8191 / 100 truncated. The product by 8191 is a
  // shift and subtract; the division is a reciprocal multiply that may come
  // out one too high, fixed by a single compare.
  function automatic logic [DUTY_W-1:0] pct_to_duty(input logic [PCT_W-1:0] pct);
    logic [19:0] prod;
    logic [32:0] recip;
    logic [12:0] q0;
    logic [19:0] back;
    logic [DUTY_W-1:0] res;
    prod  = {pct, 13'b0} - {13'b0, pct};
    recip = {13'b0, prod} * 33'd5243;
    q0    = recip[31:19];
    back  = {1'b0, q0, 6'b0} + {2'b0, q0, 5'b0} + {5'b0, q0, 2'b0};
    if (back > prod) begin
      q0 = q0 - 13'd1;
    end
    if (pct == '0) begin
      res = '0;
    end else if (pct >= 7'd100) begin
      res = DUTY_W'(DUTY_MAX);
    end else begin
      res = q0;
    end
    return res;
  endfunction

  function automatic logic [3:0] bridge_pins_of(input motor_t st);
    logic [3:0] pins;
    unique case (st)
      MOTOR_STOP:     pins = PINS_STOP;
      MOTOR_FORWARD:  pins = PINS_FORWARD;
      MOTOR_BACKWARD: pins = PINS_BACKWARD;
      MOTOR_LEFT:     pins = PINS_LEFT;
      MOTOR_RIGHT:    pins = PINS_RIGHT;
      default:        pins = PINS_STOP;
    endcase
    return pins;
  endfunction

endpackage

`default_nettype wire

[rtl/ogdc_step.sv]
// Next-state decision of the drive controller for one request.
// Depends on ogdc_pkg for the state, register and code types.
`default_nettype none

module ogdc_step (
  input  ogdc_pkg::state_t    cur,
  input  ogdc_pkg::cfg_t      cfg,
  input  logic [2:0]          func,
  input  logic [2:0]          drive_cmd,
  input  logic [15:0]         echo_us,
  input  logic                no_echo,
  output ogdc_pkg::state_t    nxt,
  output logic                forced_stop
);
  import ogdc_pkg::*;

  logic timeout;
  logic moving;

  assign timeout = no_echo || (echo_us == '0);
  // Only these motions are cut by a lost echo; reversing is left alone.
  assign moving  = (cur.drive_state == MOTOR_FORWARD) || (cur.drive_state == MOTOR_LEFT) ||
                   (cur.drive_state == MOTOR_RIGHT);

  always_comb begin
    nxt         = cur;
    forced_stop = 1'b0;
    unique case (func_t'(func))
      FUNC_MEASURE: begin
        if (timeout) begin
          if (!cur.mode_auto && moving) begin
            nxt.drive_state = MOTOR_STOP;
            nxt.duty_now    = '0;
            forced_stop     = 1'b1;
          end
        end else if (cur.mode_auto) begin
          if (cur.run_enabled) begin
            nxt.drive_state = (echo_us < cfg.auto_turn_echo) ? MOTOR_RIGHT : MOTOR_FORWARD;
            nxt.duty_now    = cfg.auto_duty;
          end
        end else if (echo_us < cfg.manual_stop_echo) begin
          nxt.drive_state = MOTOR_STOP;
          nxt.duty_now    = '0;
          forced_stop     = 1'b1;
        end
      end
      FUNC_DRIVE: begin
        unique case (drive_cmd_t'(drive_cmd))
          CMD_FORWARD: begin
            nxt.drive_state = MOTOR_FORWARD;
            nxt.duty_now    = cfg.forward_duty;
          end
          CMD_BACKWARD: begin
            nxt.drive_state = MOTOR_BACKWARD;
            nxt.duty_now    = cfg.reverse_duty;
          end
          CMD_LEFT: begin
            nxt.drive_state = MOTOR_LEFT;
            nxt.duty_now    = cfg.spin_duty;
          end
          CMD_RIGHT: begin
            nxt.drive_state = MOTOR_RIGHT;
            nxt.duty_now    = cfg.spin_duty;
          end
          CMD_STOP: begin
            nxt.drive_state = MOTOR_STOP;
            nxt.duty_now    = '0;
          end
          default: begin
          end
        endcase
      end
      FUNC_AUTO: begin
        nxt.mode_auto   = 1'b1;
        nxt.run_enabled = 1'b1;
      end
      FUNC_MANUAL: begin
        nxt.mode_auto   = 1'b0;
        nxt.drive_state = MOTOR_STOP;
        nxt.duty_now    = '0;
      end
      FUNC_PAUSE: begin
        nxt.run_enabled = 1'b0;
        nxt.drive_state = MOTOR_STOP;
        nxt.duty_now    = '0;
      end
      FUNC_RESUME: begin
        nxt.run_enabled = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/obstacle_guarded_drive_controller_unit.sv]
// Top level of the obstacle-guarded drive controller: register file, input and
// result registers, controller state. Depends on ogdc_pkg and ogdc_step.
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_we               cfg_index, cfg_wdata
//   s (item)  in         s_tvalid / s_tready  s_tdata, s_tuser
//   m (out)   out        m_tvalid / m_tready  m_tdata
//
// Each request passes through the input register and then the result register;
// one request is taken every cycle when the output side is ready. The decision
// logic sits between the two registers.
// Reset clears the state and the valid flags and sets the register file to its defaults.
// A stalled result holds; the input register fills with at most one more request
// and then s_tready stays low until the result is drained.
`default_nettype none

module obstacle_guarded_drive_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, low bit up: drive_cmd[2:0], echo_us[18:3], no_echo[19], zero pad[23:20]
  input  logic [23:0] s_tdata,
  // s_tuser: func[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, low bit up: motor_state[2:0], bridge_pins[6:3], duty_left[19:7],
  // duty_right[32:20], auto_mode[33], auto_run[34], forced_stop[35], zero pad[39:36]
  output logic [39:0] m_tdata
);
  import ogdc_pkg::*;

  localparam logic [DUTY_W-1:0] AUTO_DUTY_RST    = pct_to_duty(7'd70);
  localparam logic [DUTY_W-1:0] FORWARD_DUTY_RST = pct_to_duty(7'd70);
  localparam logic [DUTY_W-1:0] REVERSE_DUTY_RST = pct_to_duty(7'd60);
  localparam logic [DUTY_W-1:0] SPIN_DUTY_RST    = pct_to_duty(7'd65);

  cfg_t              cfg;
  state_t            state;
  state_t            state_next;
  logic              forced_next;
  logic [DUTY_W-1:0] wdata_duty;

  logic        in_valid;
  logic [2:0]  in_func;
  logic [19:0] in_data;
  logic        advance;

  assign wdata_duty = pct_to_duty(cfg_wdata[PCT_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_turn_echo   <= 16'd1458;
      cfg.manual_stop_echo <= 16'd1050;
      cfg.auto_duty        <= AUTO_DUTY_RST;
      cfg.forward_duty     <= FORWARD_DUTY_RST;
      cfg.reverse_duty     <= REVERSE_DUTY_RST;
      cfg.spin_duty        <= SPIN_DUTY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_AUTO_TURN_ECHO:   cfg.auto_turn_echo   <= cfg_wdata;
        CFG_MANUAL_STOP_ECHO: cfg.manual_stop_echo <= cfg_wdata;
        CFG_AUTO_SPEED:       cfg.auto_duty        <= wdata_duty;
        CFG_FORWARD_SPEED:    cfg.forward_duty     <= wdata_duty;
        CFG_REVERSE_SPEED:    cfg.reverse_duty     <= wdata_duty;
        CFG_SPIN_SPEED:       cfg.spin_duty        <= wdata_duty;
        default: begin
        end
      endcase
    end
  end

  // The request in the input register moves on whenever the result register
  // is empty or being drained this cycle.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_func <= s_tuser;
      in_data <= s_tdata[19:0];
    end
  end

  ogdc_step u_step (
    .cur         (state),
    .cfg         (cfg),
    .func        (in_func),
    .drive_cmd   (in_data[2:0]),
    .echo_us     (in_data[18:3]),
    .no_echo     (in_data[19]),
    .nxt         (state_next),
    .forced_stop (forced_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode_auto   <= 1'b0;
      state.run_enabled <= 1'b0;
      state.drive_state <= MOTOR_STOP;
      state.duty_now    <= '0;
      m_tvalid          <= 1'b0;
    end else if (advance && in_valid) begin
      state    <= state_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_tdata <= {4'b0, forced_next, state_next.run_enabled, state_next.mode_auto,
                  state_next.duty_now, state_next.duty_now,
                  bridge_pins_of(state_next.drive_state), state_next.drive_state};
    end
  end

endmodule

`default_nettype wire

[sim/tb_obstacle_guarded_drive_controller_unit.sv]
// Self-checking testbench for obstacle_guarded_drive_controller_unit: a queue-fed stream
// driver, a result monitor and an in-bench controller prediction. Depends on ogdc_pkg
// and the RTL of the block only.
`timescale 1ns / 1ps

module tb_obstacle_guarded_drive_controller_unit;
  import ogdc_pkg::*;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
  localparam int unsigned MAX_GAP      = 12;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_LEN     = 150;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PRINT_LIMIT  = 40;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  cmd;
    logic [15:0] echo;
    logic        no_echo;
  } drive_request_t;

  typedef struct packed {
    motor_t            motor;
    logic [3:0]        pins;
    logic [DUTY_W-1:0] duty_l;
    logic [DUTY_W-1:0] duty_r;
    logic              amode;
    logic              arun;
    logic              forced;
  } drive_report_t;

  typedef struct packed {
    logic [15:0] turn_echo;
    logic [15:0] stop_echo;
    logic [6:0]  auto_pct;
    logic [6:0]  fwd_pct;
    logic [6:0]  rev_pct;
    logic [6:0]  spin_pct;
  } guard_regs_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  obstacle_guarded_drive_controller_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  drive_request_t pending_commands[$];
  drive_report_t  expected_reports[$];

  // Predicted controller state and register copy.
  guard_regs_t       regs = '{16'd1458, 16'd1050, 7'd70, 7'd70, 7'd60, 7'd65};
  logic              ctl_auto = 1'b0;
  logic              ctl_run = 1'b0;
  motor_t            ctl_motor = MOTOR_STOP;
  logic [DUTY_W-1:0] ctl_duty = '0;

  int unsigned bad_fields = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  logic        s_idle_on = 1'b1;
  logic        r_idle_on = 1'b1;
  logic        s_taken = 1'b0;
  logic        m_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned ready_wait = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  function automatic logic [DUTY_W-1:0] percent_duty(input logic [6:0] pct);
    int unsigned d;
    if (pct == '0) begin
      d = 0;
    end else if (pct >= 7'd100) begin
      d = DUTY_MAX;
    end else begin
      d = (int'(pct) * DUTY_MAX) / 100;
    end
    return DUTY_W'(d);
  endfunction

  function automatic logic [3:0] pins_for(input motor_t m);
    logic [3:0] p;
    case (m)
      MOTOR_FORWARD:  p = PINS_FORWARD;
      MOTOR_BACKWARD: p = PINS_BACKWARD;
      MOTOR_LEFT:     p = PINS_LEFT;
      MOTOR_RIGHT:    p = PINS_RIGHT;
      default:        p = PINS_STOP;
    endcase
    return p;
  endfunction

  task automatic set_motion(input motor_t m, input logic [6:0] pct);
    ctl_motor = m;
    ctl_duty = (m == MOTOR_STOP) ? '0 : percent_duty(pct);
  endtask

  task automatic step_controller(input drive_request_t rq, output drive_report_t rpt);
    logic forced;
    forced = 1'b0;
    case (rq.func)
      FUNC_MEASURE: begin
        if (rq.no_echo || rq.echo == '0) begin
          // A lost echo only halts a manual car that could be heading into something.
          if (!ctl_auto && (ctl_motor == MOTOR_FORWARD || ctl_motor == MOTOR_LEFT ||
                            ctl_motor == MOTOR_RIGHT)) begin
            set_motion(MOTOR_STOP, '0);
            forced = 1'b1;
          end
        end else if (ctl_auto) begin
          if (ctl_run) begin
            if (rq.echo < regs.turn_echo) begin
              set_motion(MOTOR_RIGHT, regs.auto_pct);
            end else begin
              set_motion(MOTOR_FORWARD, regs.auto_pct);
            end
          end
        end else if (rq.echo < regs.stop_echo) begin
          set_motion(MOTOR_STOP, '0);
          forced = 1'b1;
        end
      end
      FUNC_DRIVE: begin
        case (rq.cmd)
          CMD_FORWARD:  set_motion(MOTOR_FORWARD, regs.fwd_pct);
          CMD_BACKWARD: set_motion(MOTOR_BACKWARD, regs.rev_pct);
          CMD_LEFT:     set_motion(MOTOR_LEFT, regs.spin_pct);
          CMD_RIGHT:    set_motion(MOTOR_RIGHT, regs.spin_pct);
          CMD_STOP:     set_motion(MOTOR_STOP, '0);
          default: ;
        endcase
      end
      FUNC_AUTO: begin
        ctl_auto = 1'b1;
        ctl_run = 1'b1;
      end
      FUNC_MANUAL: begin
        ctl_auto = 1'b0;
        set_motion(MOTOR_STOP, '0);
      end
      FUNC_PAUSE: begin
        ctl_run = 1'b0;
        set_motion(MOTOR_STOP, '0);
      end
      FUNC_RESUME: ctl_run = 1'b1;
      default: ;
    endcase
    rpt = '{ctl_motor, pins_for(ctl_motor), ctl_duty, ctl_duty, ctl_auto, ctl_run, forced};
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    bad_fields++;
    if (bad_fields <= PRINT_LIMIT) begin
      $display("%0t: result %0d: %s is %0d, predicted %0d", $time, results_seen, what,
               got, want);
    end
  endtask

  // Request side: acceptance and prediction at the rising edge.
  always @(posedge clk) begin : request_accept
    drive_request_t rq;
    drive_report_t  rpt;
    if (rst) begin
      s_taken <= 1'b0;
    end else begin
      s_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        rq = '{s_tuser, s_tdata[2:0], s_tdata[18:3], s_tdata[19]};
        step_controller(rq, rpt);
        expected_reports.push_back(rpt);
      end
    end
  end

  always @(negedge clk) begin : sender
    drive_request_t rq;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_tvalid || s_taken) begin
      if (send_gap != 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_commands.size() != 0) begin
        rq = pending_commands.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, rq.no_echo, rq.echo, rq.cmd};
        s_tuser <= rq.func;
        send_gap <= s_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    drive_report_t want;
    if (rst) begin
      m_taken <= 1'b0;
    end else begin
      m_taken <= m_tvalid && m_tready;
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected result, motor_state", m_tdata[2:0], 0);
        end else begin
          want = expected_reports.pop_front();
          if (m_tdata[2:0] !== want.motor)
            report_mismatch("motor_state", m_tdata[2:0], want.motor);
          if (m_tdata[6:3] !== want.pins)
            report_mismatch("bridge_pins", m_tdata[6:3], want.pins);
          if (m_tdata[19:7] !== want.duty_l)
            report_mismatch("duty_left", m_tdata[19:7], want.duty_l);
          if (m_tdata[32:20] !== want.duty_r)
            report_mismatch("duty_right", m_tdata[32:20], want.duty_r);
          if (m_tdata[33] !== want.amode)
            report_mismatch("auto_mode", m_tdata[33], want.amode);
          if (m_tdata[34] !== want.arun)
            report_mismatch("auto_run", m_tdata[34], want.arun);
          if (m_tdata[35] !== want.forced)
            report_mismatch("forced_stop", m_tdata[35], want.forced);
        end
      end
    end
  end

  // Result side. One long hold-off lets the block fill up and push back on requests.
  always @(negedge clk) begin : receiver
    int unsigned w;
    if (rst) begin
      m_tready <= 1'b0;
      ready_wait <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (m_taken && results_seen >= HOLD_AT && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_LEN - 1;
      hold_done <= 1'b1;
    end else if (m_taken) begin
      w = r_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (w == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        ready_wait <= w - 1;
      end
    end else if (ready_wait != 0) begin
      m_tready <= 1'b0;
      ready_wait <= ready_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_command(input logic [2:0] func, input logic [2:0] cmd,
                             input logic [15:0] echo, input logic no_echo);
    drive_request_t rq;
    rq = '{func, cmd, echo, no_echo};
    pending_commands.push_back(rq);
  endtask

  function automatic logic [15:0] echo_near(input logic [15:0] thr);
    int t;
    t = int'(thr) + int'($urandom_range(0, 8)) - 4;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return 16'(t);
  endfunction

  // Mostly measurements and drive commands, with enough mode changes to keep both modes
  // and both run states busy. Echoes cluster around the live thresholds.
  function automatic drive_request_t random_request();
    drive_request_t rq;
    int unsigned r;
    rq.cmd = 3'($urandom_range(0, 7));
    rq.echo = 16'($urandom);
    rq.no_echo = ($urandom_range(0, 99) < 12);
    r = $urandom_range(0, 99);
    if (r < 45) rq.func = FUNC_MEASURE;
    else if (r < 65) rq.func = FUNC_DRIVE;
    else if (r < 73) rq.func = FUNC_AUTO;
    else if (r < 80) rq.func = FUNC_MANUAL;
    else if (r < 86) rq.func = FUNC_PAUSE;
    else if (r < 94) rq.func = FUNC_RESUME;
    else rq.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    if (rq.func == FUNC_DRIVE && $urandom_range(0, 9) != 0) begin
      rq.cmd = 3'($urandom_range(CMD_FORWARD, CMD_STOP));
    end
    if (rq.func == FUNC_MEASURE) begin
      r = $urandom_range(0, 99);
      if (r < 10) rq.echo = '0;
      else if (r < 20) rq.echo = 16'($urandom);
      else if (r < 28) rq.echo = 16'($urandom_range(59990, 60001));
      else if (r < 30) rq.echo = 16'hFFFF;
      else if (r < 65) rq.echo = echo_near(regs.turn_echo);
      else rq.echo = echo_near(regs.stop_echo);
    end
    return rq;
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (pending_commands.size() != 0 || s_tvalid || expected_reports.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_AUTO_TURN_ECHO:   regs.turn_echo = val;
      CFG_MANUAL_STOP_ECHO: regs.stop_echo = val;
      CFG_AUTO_SPEED:       regs.auto_pct = val[6:0];
      CFG_FORWARD_SPEED:    regs.fwd_pct = val[6:0];
      CFG_REVERSE_SPEED:    regs.rev_pct = val[6:0];
      CFG_SPIN_SPEED:       regs.spin_pct = val[6:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] turn, input logic [15:0] stop,
                               input logic [15:0] auto_spd, input logic [15:0] fwd,
                               input logic [15:0] rev, input logic [15:0] spin);
    write_register(CFG_AUTO_TURN_ECHO, turn);
    write_register(CFG_MANUAL_STOP_ECHO, stop);
    write_register(CFG_AUTO_SPEED, auto_spd);
    write_register(CFG_FORWARD_SPEED, fwd);
    write_register(CFG_REVERSE_SPEED, rev);
    write_register(CFG_SPIN_SPEED, spin);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_batch(input int unsigned count, input logic s_idle,
                              input logic r_idle);
    @(posedge clk);
    s_idle_on = s_idle;
    r_idle_on = r_idle;
    repeat (count) pending_commands.push_back(random_request());
    drain();
  endtask

  initial begin : stimulus
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: thresholds 1458 and 1050 microseconds.
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd0, 1'b0);   // lost echo while stopped
    add_command(FUNC_DRIVE, CMD_FORWARD, 16'hFFFF, 1'b1);
    add_command(FUNC_MEASURE, CMD_STOP, 16'hFFFF, 1'b1);   // no echo halts forward
    add_command(FUNC_DRIVE, CMD_LEFT, 16'd0, 1'b0);
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd0, 1'b0);   // zero count halts a spin
    add_command(FUNC_DRIVE, CMD_RIGHT, 16'd0, 1'b0);
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd1049, 1'b0);
    add_command(FUNC_DRIVE, CMD_BACKWARD, 16'd0, 1'b0);
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd0, 1'b1);   // reversing ignores a lost echo
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd1050, 1'b0);
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd1, 1'b0);
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd500, 1'b0); // already stopped, still flagged
    add_command(FUNC_DRIVE, CMD_FORWARD, 16'd0, 1'b0);
    add_command(FUNC_DRIVE, CMD_SPARE_LO, 16'd0, 1'b0);
    add_command(FUNC_DRIVE, CMD_SPARE_HI, 16'd0, 1'b0);
    add_command(FUNC_AUTO, CMD_FORWARD, 16'd0, 1'b0);
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd1457, 1'b0);
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd1458, 1'b0);
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'hFFFF, 1'b0);
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd0, 1'b1);   // automatic ignores a lost echo
    add_command(FUNC_PAUSE, CMD_FORWARD, 16'd0, 1'b0);
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd100, 1'b0);
    add_command(FUNC_RESUME, CMD_FORWARD, 16'd0, 1'b0);
    add_command(FUNC_MEASURE, CMD_FORWARD, 16'd60001, 1'b0);
    add_command(FUNC_SPARE_LO, CMD_FORWARD, 16'd0, 1'b0);
    add_command(FUNC_SPARE_HI, CMD_FORWARD, 16'd0, 1'b0);
    add_command(FUNC_MANUAL, CMD_FORWARD, 16'd0, 1'b0);
    drain();

    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_batch(235, 1'b1, 1'b1);

    // The long receiver hold-off lands in this batch, with the sender never pausing.
    load_settings(16'hFFFF, 16'hFFFF, 16'd127, 16'd100, 16'd99, 16'd1);
    random_batch(235, 1'b0, 1'b0);

    load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    random_batch(235, 1'b1, 1'b0);

    load_settings(16'($urandom_range(0, 60001)), 16'($urandom_range(0, 60001)),
                  16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
                  16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)));
    random_batch(235, 1'b0, 1'b1);

    load_settings(16'd1458, 16'd1050, 16'd70, 16'd70, 16'd60, 16'd65);
    random_batch(235, 1'b1, 1'b1);

    repeat (8) @(posedge clk);
    if (expected_reports.size() != 0) begin
      report_mismatch("results never delivered", 0, expected_reports.size());
    end
    if (bad_fields == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[obstacle_guarded_drive_controller_unit.f]
rtl/ogdc_pkg.sv
rtl/ogdc_step.sv
rtl/obstacle_guarded_drive_controller_unit.sv
sim/tb_obstacle_guarded_drive_controller_unit.sv
